@@ hw/rtl/swrr_pkg.sv @@
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared constants, codes and types for the stack with rotate and reverse.
// ----------------------------------------------------------------------------
`default_nettype none

package swrr_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 7;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int KIND_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_ROTATE  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;

  // One cycle's access to the entry store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Bits kept on push for each element kind; the unused codes keep all 64.
  function automatic logic [DATA_W-1:0] kind_mask(input logic [KIND_W-1:0] kind);
    logic [DATA_W-1:0] m;
    case (kind)
      KIND_BYTE:   m = {{(DATA_W-8){1'b0}}, 8'hFF};
      KIND_SINGLE: m = {{(DATA_W-32){1'b0}}, 32'hFFFF_FFFF};
      default:     m = '1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/swrr_ram.sv @@
// ----------------------------------------------------------------------------
// swrr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/swrr_seq.sv @@
// ----------------------------------------------------------------------------
// swrr_seq
// Operation sequencer: fill count, store walks for rotate and reverse,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swrr_pkg::MODE_W-1:0]  in_mode,
  input  logic [swrr_pkg::DATA_W-1:0]  push_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swrr_pkg::DATA_W-1:0]  out_pop_value,
  output logic [swrr_pkg::STAT_W-1:0]  out_status,
  output logic [swrr_pkg::ENTRY_W-1:0] out_entry_count,
  output swrr_pkg::mem_req_t           mem_req,
  input  logic [swrr_pkg::DATA_W-1:0]  rd_data
);

  import swrr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_ROT,
    S_ROT_LAST,
    S_REV_RD,
    S_REV_WLO,
    S_REV_WHI
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;    // rotate read pointer / reverse low index
  logic [ADDR_W-1:0]   hi_r, hi_nxt;      // reverse high index
  logic [DATA_W-1:0]   hold_r, hold_nxt;  // rotated bottom word / swapped low word
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_pop_r, out_pop_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]  out_count_r, out_count_nxt;

  logic                load;
  logic [DATA_W-1:0]   ld_pop;
  logic [STAT_W-1:0]   ld_status;
  logic [ADDR_W-1:0]   last_idx;
  logic                accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign last_idx = ADDR_W'(fill_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    hi_nxt        = hi_r;
    hold_nxt      = hold_r;
    mem_req       = '0;
    load          = 1'b0;
    ld_pop        = '0;
    ld_status     = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_mode))
            OP_PUSH: begin
              load = 1'b1;
              if (fill_r == CNT_W'(DEPTH)) begin
                ld_status = ST_OVERFLOW;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(fill_r);
                mem_req.wdata = push_word;
                fill_nxt      = fill_r + 1'b1;
              end
            end
            OP_POP: begin
              if (fill_r == '0) begin
                load      = 1'b1;
                ld_status = ST_UNDERFLOW;
              end else begin
                mem_req.raddr = last_idx;
                fill_nxt      = fill_r - 1'b1;
                state_nxt     = S_POP;
              end
            end
            OP_ROTATE: begin
              if (fill_r == '0) begin
                load = 1'b1;
              end else begin
                mem_req.raddr = '0;
                ptr_nxt       = '0;
                state_nxt     = S_ROT;
              end
            end
            default: begin
              if (fill_r < CNT_W'(2)) begin
                load = 1'b1;
              end else begin
                mem_req.raddr = '0;
                ptr_nxt       = '0;
                hi_nxt        = last_idx;
                state_nxt     = S_REV_RD;
              end
            end
          endcase
        end
      end
      S_POP: begin
        load      = 1'b1;
        ld_pop    = rd_data;
        state_nxt = S_IDLE;
      end
      S_ROT: begin
        // rd_data holds entry ptr_r; it moves down one slot, or is held if it is entry 0
        if (ptr_r == '0) begin
          hold_nxt = rd_data;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ptr_r - 1'b1;
          mem_req.wdata = rd_data;
        end
        if (ptr_r == last_idx) begin
          state_nxt = S_ROT_LAST;
        end else begin
          mem_req.raddr = ptr_r + 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end
      end
      S_ROT_LAST: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = last_idx;
        mem_req.wdata = hold_r;
        load          = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REV_RD: begin
        mem_req.raddr = hi_r;
        hold_nxt      = rd_data;
        state_nxt     = S_REV_WLO;
      end
      S_REV_WLO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rd_data;
        state_nxt     = S_REV_WHI;
      end
      S_REV_WHI: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hi_r;
        mem_req.wdata = hold_r;
        if (({1'b0, ptr_r} + (ADDR_W + 1)'(2)) < {1'b0, hi_r}) begin
          mem_req.raddr = ptr_r + 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
          hi_nxt        = hi_r - 1'b1;
          state_nxt     = S_REV_RD;
        end else begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pop_nxt    = out_pop_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_pop_nxt    = ld_pop;
      out_status_nxt = ld_status;
      out_count_nxt  = ENTRY_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    hi_r         <= hi_nxt;
    hold_r       <= hold_nxt;
    out_pop_r    <= out_pop_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pop_value   = out_pop_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

@@ hw/rtl/stack_with_rotate_reverse.sv @@
// ----------------------------------------------------------------------------
// stack_with_rotate_reverse
// LIFO stack of 64-bit words with push, pop, rotate and reverse.
// ----------------------------------------------------------------------------
// Each input transaction carries one operation and yields exactly one result
// transaction (popped word, status, entry count after the operation). Words
// live in a single 64-entry RAM with one write and one registered read port,
// and that single port pair sets the timing: push, overflowing push, pop on
// empty, and rotate or reverse of a trivially short stack load their result
// on acceptance; pop reads the top entry, then loads it; rotate reads each
// entry in turn, writes it one slot down behind the read, then writes the
// bottom word on top; reverse swaps pairs from the ends inward (read low,
// read high, write low, write high per swap, the next read overlapping the
// last write). A new transaction is taken only while the block is idle and
// the output register is empty or its result leaves in that same cycle, so
// a stalled result holds off the input. The user must write the element kind
// register only while the block is idle; the block does not enforce this.
// The register masks pushed words to 8, 32 or 64 bits. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_rotate_reverse (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swrr_pkg::KIND_W-1:0]  cfg_element_kind,
  // operation transactions
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swrr_pkg::MODE_W-1:0]  in_mode,
  input  logic [swrr_pkg::DATA_W-1:0]  in_push_value,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swrr_pkg::DATA_W-1:0]  out_pop_value,
  output logic [swrr_pkg::STAT_W-1:0]  out_status,
  output logic [swrr_pkg::ENTRY_W-1:0] out_entry_count
);

  import swrr_pkg::*;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [DATA_W-1:0] push_word;
  logic [DATA_W-1:0] rd_data;
  mem_req_t          mem_req;

  // Config register: always ready; the user must write it only between operations, which the block does not enforce.
  assign cfg_ready = 1'b1;
  assign kind_nxt  = (cfg_valid && cfg_ready) ? cfg_element_kind : kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_BYTE;
    end else begin
      kind_r <= kind_nxt;
    end
  end

  // Pushed words are trimmed to the element width before storage.
  assign push_word = in_push_value & kind_mask(kind_r);

  swrr_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .push_word       (push_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pop_value   (out_pop_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

  // Entry store, entry 0 at the bottom of the stack.
  swrr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/swrr_chk.sv @@
// ----------------------------------------------------------------------------
// swrr_chk
// Port-level checks for the stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [swrr_pkg::DATA_W-1:0]  out_pop_value,
  input  logic [swrr_pkg::STAT_W-1:0]  out_status,
  input  logic [swrr_pkg::ENTRY_W-1:0] out_entry_count
);

  import swrr_pkg::*;

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OVERFLOW ||
                   out_status == ST_UNDERFLOW))
    else $error("undefined status code");

  // Overflow only happens on a full stack and returns no word.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |->
      (out_entry_count == ENTRY_W'(DEPTH) && out_pop_value == '0))
    else $error("overflow reported on a stack that is not full");

  // Underflow only happens on an empty stack and returns zero.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |->
      (out_entry_count == '0 && out_pop_value == '0))
    else $error("underflow reported on a stack that is not empty");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pop_value) && $stable(out_status) &&
       $stable(out_entry_count)))
    else $error("result changed while stalled");

endmodule

bind stack_with_rotate_reverse swrr_chk u_swrr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pop_value   (out_pop_value),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

`default_nettype wire
